// ----- hdl/u16u8_pkg.sv -----
// shared types, constants and the utf-8 encoder function of the transcoder
package u16u8_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
    localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
    localparam logic [15:0] SURR_END     = 16'hE000;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [20:0] REPLACEMENT  = 21'h00FFFD;

    // one queued job: optional replacement char first, then optional scalar
    typedef struct packed {
        logic        pre_rep;
        logic        main_vld;
        logic [20:0] cp;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } t_enc;

    function automatic t_enc utf8_encode(input logic [20:0] cp);
        t_enc e;
        e.bytes = '0;
        if (cp < 21'h000080) begin
            e.last_idx = 2'd0;
            e.bytes[0] = cp[7:0];
        end else if (cp < 21'h000800) begin
            e.last_idx = 2'd1;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < SUPP_BASE) begin
            e.last_idx = 2'd2;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            e.last_idx = 2'd3;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

endpackage

// ----- hdl/u16u8_front.sv -----
// front part: accepts code units, pairs surrogates and builds queue jobs
module u16u8_front import u16u8_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic       r_pend_vld, n_pend_vld;
    logic [9:0] r_pend_bits, n_pend_bits;
    logic       accept;
    logic       is_high;
    logic       is_low;
    t_cmd       cmd;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign is_high = (i_code_unit >= SURR_HIGH_LO) && (i_code_unit < SURR_LOW_LO);
    assign is_low  = (i_code_unit >= SURR_LOW_LO) && (i_code_unit < SURR_END);

    always_comb begin
        n_pend_vld   = r_pend_vld;
        n_pend_bits  = r_pend_bits;
        cmd.pre_rep  = 1'b0;
        cmd.main_vld = 1'b1;
        cmd.cp       = {5'd0, i_code_unit};
        cmd.last     = i_last_unit;
        if (r_pend_vld && is_low) begin
            cmd.cp = SUPP_BASE + {1'b0, r_pend_bits, i_code_unit[9:0]};
        end else begin
            cmd.pre_rep = r_pend_vld;
            if (is_high) begin
                if (i_last_unit) begin
                    cmd.cp = REPLACEMENT;
                end else begin
                    cmd.main_vld = 1'b0;
                end
            end else if (is_low) begin
                cmd.cp = REPLACEMENT;
            end
        end
        if (accept) begin
            n_pend_vld  = is_high && !i_last_unit;
            n_pend_bits = n_pend_vld ? i_code_unit[9:0] : '0;
        end
    end

    assign o_push = accept && (cmd.pre_rep || cmd.main_vld);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld  <= 1'b0;
            r_pend_bits <= '0;
        end else begin
            r_pend_vld  <= n_pend_vld;
            r_pend_bits <= n_pend_bits;
        end
    end

endmodule

// ----- hdl/u16u8_queue.sv -----
// short job queue between the front and back parts
module u16u8_queue import u16u8_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

// ----- hdl/u16u8_back.sv -----
// back part: serialises queued jobs into utf-8 bytes, one per cycle while the output is not stalled
module u16u8_back import u16u8_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_utf8_byte,
    output logic       o_end_of_string
);

    logic        r_act_vld, n_act_vld;
    logic        r_rep, n_rep;
    logic        r_main_vld, n_main_vld;
    logic [20:0] r_cp, n_cp;
    logic        r_last, n_last;
    logic [1:0]  r_idx, n_idx;
    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic        r_out_eos;
    logic        out_ready;
    logic        final_byte;
    logic        job_done;
    logic        pop;
    t_enc        enc;

    assign out_ready  = !r_out_vld || !i_stall;
    assign enc        = utf8_encode(r_rep ? REPLACEMENT : r_cp);
    assign final_byte = (r_idx == enc.last_idx);
    assign job_done   = final_byte && !(r_rep && r_main_vld);
    assign pop        = !i_q_empty && (!r_act_vld || (out_ready && job_done));
    assign o_pop      = pop;

    always_comb begin
        n_act_vld  = r_act_vld;
        n_rep      = r_rep;
        n_main_vld = r_main_vld;
        n_cp       = r_cp;
        n_last     = r_last;
        n_idx      = r_idx;
        if (pop) begin
            n_act_vld  = 1'b1;
            n_rep      = i_cmd.pre_rep;
            n_main_vld = i_cmd.main_vld;
            n_cp       = i_cmd.cp;
            n_last     = i_cmd.last;
            n_idx      = '0;
        end else if (r_act_vld && out_ready) begin
            if (job_done) begin
                n_act_vld = 1'b0;
            end else if (final_byte) begin
                n_rep = 1'b0;
                n_idx = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_act_vld <= n_act_vld;
            if (out_ready) begin
                r_out_vld <= r_act_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep      <= n_rep;
        r_main_vld <= n_main_vld;
        r_cp       <= n_cp;
        r_last     <= n_last;
        r_idx      <= n_idx;
        if (out_ready) begin
            r_out_byte <= enc.bytes[r_idx];
            r_out_eos  <= r_last && job_done;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_utf8_byte     = r_out_byte;
    assign o_end_of_string = r_out_eos;

endmodule

// ----- hdl/utf16_to_utf8_transcoder_unit.sv -----
// top level of the utf-16 to utf-8 transcoder
//
// input channel: one utf-16 code unit per transfer (i_valid, o_stall), with
// i_last_unit marking the final unit of a string. output channel: one utf-8
// byte per transfer (o_valid, i_stall), o_end_of_string on the final byte.
// a high surrogate is held until the next unit; unpaired surrogates come
// out as u+fffd (ef bf bd).
// the front part classifies each unit and pushes at most one job into a short
// queue; the back part turns jobs into bytes at one byte per cycle while the
// output is not stalled.
// throughput is set by the back part's byte serialiser, which sends each byte of a
// unit in turn (1 to 3 bytes, 4 for a pair, up to 6 with a replacement).
// the front takes a unit every cycle while the queue has room.
// reset clears the held surrogate, the queue and the output register.
// when the receiver stalls, the output byte holds, the back part waits and
// the queue fills; o_stall rises only when the queue is full.
module utf16_to_utf8_transcoder_unit import u16u8_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_utf8_byte,
    output logic        o_end_of_string
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    u16u8_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    u16u8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_utf8_byte     (o_utf8_byte),
        .o_end_of_string (o_end_of_string)
    );

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench of the utf-16 to utf-8 transcoder with its own byte predictor
module tb_top;
    import u16u8_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_utf8_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_code_unit = '0;
    logic        i_last_unit = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_utf8_byte;
    logic        o_end_of_string;

    t_utf8_out   utf8_expected[$];
    logic [7:0]  char_bytes[$];
    logic        held_high = 1'b0;
    logic [9:0]  held_bits = '0;
    int          n_mismatch = 0;
    int          n_sent = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          rx_hold_req = 1'b0;
    int          rx_hold_left = 0;

    utf16_to_utf8_transcoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_code_unit     (i_code_unit),
        .i_last_unit     (i_last_unit),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_utf8_byte     (o_utf8_byte),
        .o_end_of_string (o_end_of_string)
    );

    always #2 i_clk = ~i_clk;

    function automatic void encode_char(input logic [20:0] cp);
        if (cp < 21'h80) begin
            char_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            char_bytes.push_back(8'hC0 | 8'(cp >> 6));
            char_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
        end else if (cp < SUPP_BASE) begin
            char_bytes.push_back(8'hE0 | 8'(cp >> 12));
            char_bytes.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
            char_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
        end else begin
            char_bytes.push_back(8'hF0 | 8'((cp >> 18) & 21'h07));
            char_bytes.push_back(8'h80 | 8'((cp >> 12) & 21'h3F));
            char_bytes.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
            char_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
        end
    endfunction

    function automatic void predict_bytes(input logic [15:0] cu, input logic lu);
        logic is_hi;
        logic is_lo;
        is_hi = (cu >= SURR_HIGH_LO) && (cu < SURR_LOW_LO);
        is_lo = (cu >= SURR_LOW_LO) && (cu < SURR_END);
        char_bytes.delete();
        if (held_high && is_lo) begin
            encode_char(SUPP_BASE + 21'({held_bits, 10'b0}) + 21'(cu - SURR_LOW_LO));
            held_high = 1'b0;
        end else begin
            if (held_high) begin
                encode_char(REPLACEMENT);
                held_high = 1'b0;
            end
            if (is_hi) begin
                if (lu) begin
                    encode_char(REPLACEMENT);
                end else begin
                    held_high = 1'b1;
                    held_bits = cu[9:0];
                end
            end else if (is_lo) begin
                encode_char(REPLACEMENT);
            end else begin
                encode_char(21'(cu));
            end
        end
        foreach (char_bytes[k])
            utf8_expected.push_back('{data: char_bytes[k],
                                      eos: lu && (k == char_bytes.size() - 1)});
    endfunction

    task automatic send_unit(input logic [15:0] cu, input logic lu);
        while (tx_idle_en && $urandom_range(0, 99) < 26) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= cu;
        i_last_unit <= lu;
        do @(posedge i_clk); while (o_stall);
        predict_bytes(cu, lu);
        n_sent++;
    endtask

    task automatic wait_output_empty();
        i_valid <= 1'b0;
        while (utf8_expected.size() != 0) @(posedge i_clk);
        // a held high surrogate gives no byte, so allow the pipe to settle
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random_char(input logic lu);
        logic [19:0] v;
        logic [15:0] u;
        case ($urandom_range(0, 3))
            0: send_unit(16'($urandom_range(0, 'h7F)), lu);
            1: send_unit(16'($urandom_range('h80, 'h7FF)), lu);
            2: begin
                u = 16'($urandom_range('h800, 'hF7FF));
                if (u >= SURR_HIGH_LO) u = u + 16'h0800;
                send_unit(u, lu);
            end
            default: begin
                v = 20'($urandom());
                send_unit(SURR_HIGH_LO + 16'(v[19:10]), 1'b0);
                send_unit(SURR_LOW_LO + 16'(v[9:0]), lu);
            end
        endcase
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_unit(16'($urandom()), 1'($urandom_range(0, 1)));
            1: begin
                send_unit(SURR_HIGH_LO + 16'($urandom_range(0, 'h3FF)), 1'b0);
                send_random_char(1'($urandom_range(0, 1)));
            end
            default: send_unit(SURR_LOW_LO + 16'($urandom_range(0, 'h3FF)),
                               1'($urandom_range(0, 1)));
        endcase
    endtask

    task automatic send_random_string();
        int len;
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++)
            send_random_char(k == len - 1);
    endtask

    task automatic test_bmp_extremes();
        send_unit(16'h0000, 1'b1);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b1);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFD, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        wait_output_empty();
    endtask

    task automatic test_surrogate_cases();
        // lowest and highest pairs
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b1);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // held high broken by ascii, then by a 3-byte char
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDA12, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        // held high replaced by a new high, which then pairs
        send_unit(16'hDB00, 1'b0);
        send_unit(16'hD9AB, 1'b0);
        send_unit(16'hDE01, 1'b1);
        // high ending the string, lone lows
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // held high followed by a high that ends the string
        send_unit(16'hD811, 1'b0);
        send_unit(16'hD822, 1'b1);
        wait_output_empty();
    endtask

    task automatic test_random_strings();
        int goal;
        goal = n_sent + 40;
        while (n_sent < goal) begin
            if ($urandom_range(0, 99) < 80) send_random_string();
            else send_noise();
        end
        wait_output_empty();
    endtask

    task automatic test_input_backpressure();
        int goal;
        rx_hold_req = 1'b1;
        goal = n_sent + 15;
        while (n_sent < goal) send_random_string();
        wait_output_empty();
    endtask

    task automatic test_burst_no_idle();
        int goal;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        goal = n_sent + 20;
        while (n_sent < goal) begin
            if ($urandom_range(0, 99) < 85) send_random_string();
            else send_noise();
        end
        wait_output_empty();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // output side: check each transfer, then choose the next stall
    always @(posedge i_clk) begin
        t_utf8_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (utf8_expected.size() == 0) begin
                $error("unexpected byte: utf8_byte=%h end_of_string=%b",
                       o_utf8_byte, o_end_of_string);
                n_mismatch++;
            end else begin
                want = utf8_expected.pop_front();
                if (o_utf8_byte !== want.data) begin
                    $error("utf8_byte: expected %h, got %h", want.data, o_utf8_byte);
                    n_mismatch++;
                end
                if (o_end_of_string !== want.eos) begin
                    $error("end_of_string: expected %b, got %b", want.eos,
                           o_end_of_string);
                    n_mismatch++;
                end
            end
        end
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_left = 80;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= rx_idle_en && ($urandom_range(0, 99) < 26);
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bmp_extremes();
        test_surrogate_cases();
        test_random_strings();
        test_input_backpressure();
        test_burst_no_idle();
        if (n_mismatch == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
